### sv/matrix4_multiply_macros.svh
// Assertion macros for the matrix4_multiply block.
// Included by the top level; relies on signals clk and rst_n in scope.
`ifndef MATRIX4_MULTIPLY_MACROS_SVH
`define MATRIX4_MULTIPLY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MM4_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix4_multiply: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MM4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix4_multiply: next-cycle check failed");

`endif

### sv/mm4_pkg.sv
// Package for the matrix4_multiply block: sizes, action codes, pipeline tags
// and the output saturation function. No dependencies.
`default_nettype none

package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int FIELD_W   = 2;
  localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int DEPTH     = DIM * DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(DIM);

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_LOAD_A   = 2'd0,
    ACT_LOAD_B   = 2'd1,
    ACT_MULTIPLY = 2'd2
  } action_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  typedef struct packed {
    logic                    valid;
    logic                    last_elem;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] sum;
  } mac_res_t;

  function automatic logic [DATA_W-1:0] saturate(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] shifted;
    shifted = acc >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      return SAT_HI[DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      return SAT_LO[DATA_W-1:0];
    end
    return shifted[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/mm4_if.sv
// Valid/ready channel interfaces for the matrix4_multiply block.
// Depends on mm4_pkg for field widths.
`default_nettype none

interface mm4_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [mm4_pkg::FIELD_W-1:0] row;
  logic [mm4_pkg::FIELD_W-1:0] col;
  logic signed [mm4_pkg::DATA_W-1:0] value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface mm4_out_if;
  logic                        valid;
  logic                        ready;
  logic [mm4_pkg::FIELD_W-1:0] out_row;
  logic [mm4_pkg::FIELD_W-1:0] out_col;
  logic signed [mm4_pkg::DATA_W-1:0] product;
  logic                        last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

`default_nettype wire

### sv/mm4_store.sv
// Matrix element store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Depends on mm4_pkg.
`default_nettype none

module mm4_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [mm4_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [mm4_pkg::DATA_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [mm4_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [mm4_pkg::DATA_W-1:0]  rd_data
);

  logic [mm4_pkg::DATA_W-1:0] mem [mm4_pkg::DEPTH];
  logic [mm4_pkg::DEPTH-1:0]  written_r;
  logic [mm4_pkg::DATA_W-1:0] rd_word_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

`default_nettype wire

### sv/mm4_mac.sv
// Multiply-accumulate pipeline: aligns tags with store read data, registers
// each product and accumulates one dot product at full width. Depends on mm4_pkg.
`default_nettype none

module mm4_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire mm4_pkg::mac_tag_t                tag_in,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] a,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] b,
  output mm4_pkg::mac_res_t                     res
);

  mm4_pkg::mac_tag_t tag1_r;
  mm4_pkg::mac_tag_t tag2_r;
  mm4_pkg::mac_tag_t tag3_r;
  logic signed [mm4_pkg::PROD_W-1:0] prod_r;
  logic signed [mm4_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
      if (tag2_r.valid) begin
        if (tag2_r.first) begin
          acc_r <= mm4_pkg::ACC_W'(prod_r);
        end else begin
          acc_r <= acc_r + mm4_pkg::ACC_W'(prod_r);
        end
      end
    end
  end

  assign res.valid     = tag3_r.valid && tag3_r.last_k;
  assign res.last_elem = tag3_r.last_elem;
  assign res.row       = tag3_r.row;
  assign res.col       = tag3_r.col;
  assign res.sum       = acc_r;

endmodule

`default_nettype wire

### sv/matrix4_multiply.sv
// Top level of the 4x4 signed Q16.16 matrix multiplier.
// Depends on mm4_pkg, mm4_if, mm4_store, mm4_mac and matrix4_multiply_macros.svh.
// A load item writes one element into the first or second matrix store. A
// multiply item issues one multiply-accumulate per cycle, one read of each store
// per cycle, while the result side does not stall, and sums four products into
// each product element. The next item is accepted only after the last product
// element has been transferred, so loads never overlap the reads of a multiply.
// Both stores read as zero after reset until written.
`default_nettype none

`include "matrix4_multiply_macros.svh"

module matrix4_multiply (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mm4_in_if.sink     in_chan,
  mm4_out_if.source  out_chan
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic [mm4_pkg::IDX_W-1:0] IDX_LAST = mm4_pkg::IDX_W'(mm4_pkg::DIM - 1);

  state_t                         state_r;
  logic                           issue_r;
  logic [mm4_pkg::IDX_W-1:0]      i_r;
  logic [mm4_pkg::IDX_W-1:0]      j_r;
  logic [mm4_pkg::IDX_W-1:0]      k_r;
  logic                           out_valid_r;
  logic [mm4_pkg::FIELD_W-1:0]    out_row_r;
  logic [mm4_pkg::FIELD_W-1:0]    out_col_r;
  logic [mm4_pkg::DATA_W-1:0]     out_prod_r;
  logic                           out_last_r;

  logic                           adv;
  logic                           in_xfer;
  logic                           in_idx_ok;
  logic [mm4_pkg::ADDR_W-1:0]     wr_addr;
  logic [mm4_pkg::ADDR_W-1:0]     a_addr;
  logic [mm4_pkg::ADDR_W-1:0]     b_addr;
  logic [mm4_pkg::DATA_W-1:0]     a_data;
  logic [mm4_pkg::DATA_W-1:0]     b_data;
  logic                           issue_last;
  mm4_pkg::mac_tag_t              tag;
  mm4_pkg::mac_res_t              res;

  assign adv        = !out_valid_r || out_chan.ready;
  assign in_xfer    = in_chan.valid && in_chan.ready;
  assign in_idx_ok  = (int'(in_chan.row) < mm4_pkg::DIM) && (int'(in_chan.col) < mm4_pkg::DIM);
  assign wr_addr    = mm4_pkg::ADDR_W'(int'(in_chan.row) * mm4_pkg::DIM + int'(in_chan.col));
  assign a_addr     = mm4_pkg::ADDR_W'(int'(i_r) * mm4_pkg::DIM + int'(k_r));
  assign b_addr     = mm4_pkg::ADDR_W'(int'(k_r) * mm4_pkg::DIM + int'(j_r));
  assign issue_last = (i_r == IDX_LAST) && (j_r == IDX_LAST) && (k_r == IDX_LAST);

  assign tag.valid     = issue_r;
  assign tag.first     = (k_r == '0);
  assign tag.last_k    = (k_r == IDX_LAST);
  assign tag.last_elem = issue_last;
  assign tag.row       = i_r;
  assign tag.col       = j_r;

  mm4_store u_store_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && in_idx_ok && (in_chan.action == mm4_pkg::ACT_LOAD_A)),
    .wr_addr (wr_addr),
    .wr_data (in_chan.value),
    .rd_en   (adv),
    .rd_addr (a_addr),
    .rd_data (a_data)
  );

  mm4_store u_store_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && in_idx_ok && (in_chan.action == mm4_pkg::ACT_LOAD_B)),
    .wr_addr (wr_addr),
    .wr_data (in_chan.value),
    .rd_en   (adv),
    .rd_addr (b_addr),
    .rd_data (b_data)
  );

  mm4_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .tag_in (tag),
    .a      (a_data),
    .b      (b_data),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_chan.action == mm4_pkg::ACT_MULTIPLY)) begin
            state_r <= ST_RUN;
            issue_r <= 1'b1;
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
          end
        end
        ST_RUN: begin
          if (issue_r && adv) begin
            k_r <= (k_r == IDX_LAST) ? '0 : k_r + 1'b1;
            if (k_r == IDX_LAST) begin
              j_r <= (j_r == IDX_LAST) ? '0 : j_r + 1'b1;
              if (j_r == IDX_LAST) begin
                i_r <= (i_r == IDX_LAST) ? '0 : i_r + 1'b1;
              end
            end
            if (issue_last) begin
              issue_r <= 1'b0;
            end
          end
          if (out_valid_r && out_chan.ready && out_last_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (adv) begin
        out_valid_r <= res.valid;
      end
    end
    if (adv && res.valid) begin
      out_row_r  <= mm4_pkg::FIELD_W'(res.row);
      out_col_r  <= mm4_pkg::FIELD_W'(res.col);
      out_prod_r <= mm4_pkg::saturate(res.sum);
      out_last_r <= res.last_elem;
    end
  end

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.out_row = out_row_r;
  assign out_chan.out_col = out_col_r;
  assign out_chan.product = out_prod_r;
  assign out_chan.last    = out_last_r;

  `MM4_ASSERT_NEXT(a_last_to_idle, out_chan.valid && out_chan.ready && out_chan.last, state_r == ST_IDLE)
  `MM4_ASSERT_SAME(a_idle_no_result, state_r == ST_IDLE, !out_valid_r && !issue_r)
  `MM4_ASSERT_NEXT(a_mul_starts_issue, in_chan.valid && in_chan.ready && (in_chan.action == mm4_pkg::ACT_MULTIPLY), issue_r && (state_r == ST_RUN))

endmodule

`default_nettype wire
